>>> hdl/assert_macros.svh
// Assertion macros shared by the score table RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in score table");

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in score table");

`endif

>>> hdl/tks_pkg.sv
// Package for the top-k score table: sizes, command codes and shared types.
// Used by tks_cell and top_k_score_table_top; depends on nothing.
`timescale 1ns / 1ps

package tks_pkg;

  localparam int LIST_DEPTH  = 10;
  localparam int BANKS       = 5;
  localparam int SCORE_BITS  = 20;
  localparam int INI_BITS    = 8;
  localparam int BANK_W      = 3;
  localparam int RANK_W      = 4;
  localparam int BANK_IDX_W  = $clog2(BANKS);
  localparam int LAST_RANK   = LIST_DEPTH - 1;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // One stored entry: a score and three initial bytes
  typedef struct packed {
    logic [SCORE_BITS-1:0] score;
    logic [INI_BITS-1:0]   ini_a;
    logic [INI_BITS-1:0]   ini_b;
    logic [INI_BITS-1:0]   ini_c;
  } entry_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic                  wr_en;
    logic [BANK_IDX_W-1:0] bank;
  } cell_ctl_t;

  // One result item
  typedef struct packed {
    logic              accepted;
    logic [RANK_W-1:0] rank;
    entry_t            entry;
  } result_t;

endpackage

>>> hdl/tks_cell.sv
// One rank position of the score table, holding that rank's entry for every bank.
// Depends on tks_pkg; chained by top_k_score_table_top.
`timescale 1ns / 1ps

module tks_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tks_pkg::cell_ctl_t ctl,
  input  tks_pkg::entry_t    new_entry,
  input  tks_pkg::entry_t    up_entry,
  input  logic               up_ge,
  output tks_pkg::entry_t    cur_entry,
  output logic               cur_ge
);

  tks_pkg::entry_t store_r [tks_pkg::BANKS];
  tks_pkg::entry_t store_nxt;
  logic            wr;

  // Read this rank of the addressed bank and compare against the offered score
  assign cur_entry = store_r[ctl.bank];
  assign cur_ge    = (cur_entry.score >= new_entry.score);

  // Take the new entry at the insert spot, otherwise shift down from the cell above
  assign store_nxt = up_ge ? new_entry : up_entry;
  assign wr        = ctl.wr_en && !cur_ge;

  // Hold the entries; clear all banks at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < tks_pkg::BANKS; b++) begin
        store_r[b] <= '0;
      end
    end else if (wr) begin
      store_r[ctl.bank] <= store_nxt;
    end
  end

endmodule

>>> hdl/top_k_score_table_top.sv
// Top-k score table: five descending top-10 lists built from a chain of rank cells.
// Depends on tks_pkg, tks_cell and assert_macros.svh.
//
// Usage:
//   Drive the in_ fields and raise start; the command is taken at the rising edge where
//   start is high and busy is low. busy stays low: every cell compares its entry with the
//   offered score in parallel and shifts in the same cycle, so one command per clock.
//   An insert (in_command 0) keeps the entry only if its score beats the bank's last
//   entry; it lands below all equal or greater scores and the last entry drops out.
//   A read (in_command 1) returns the entry at in_read_rank, saturated to the last rank.
//   Each command gives one result on the out_ ports, marked by out_valid for exactly one
//   cycle, in the cycle after the transfer. The next command already sees the updated list.
//   A bank number out of range changes nothing and returns all zeros.
//   The receiver cannot stall; results must be taken when out_valid is high.
//   Reset (rst_n low, synchronous) clears every list to zero scores and initials and
//   drops any pending result. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module top_k_score_table_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_command,
  input  logic [tks_pkg::BANK_W-1:0]     in_bank,
  input  logic [tks_pkg::SCORE_BITS-1:0] in_new_score,
  input  logic [tks_pkg::INI_BITS-1:0]   in_initial_a,
  input  logic [tks_pkg::INI_BITS-1:0]   in_initial_b,
  input  logic [tks_pkg::INI_BITS-1:0]   in_initial_c,
  input  logic [tks_pkg::RANK_W-1:0]     in_read_rank,
  output logic                           out_valid,
  output logic                           out_accepted,
  output logic [tks_pkg::RANK_W-1:0]     out_rank,
  output logic [tks_pkg::SCORE_BITS-1:0] out_entry_score,
  output logic [tks_pkg::INI_BITS-1:0]   out_entry_initial_a,
  output logic [tks_pkg::INI_BITS-1:0]   out_entry_initial_b,
  output logic [tks_pkg::INI_BITS-1:0]   out_entry_initial_c
);

  logic                                in_xfer;
  logic                                bank_ok;
  logic                                kept;
  logic [tks_pkg::RANK_W-1:0]          rd_rank;
  logic [tks_pkg::RANK_W-1:0]          ins_rank;
  logic [tks_pkg::LIST_DEPTH-1:0]      cell_ge;
  logic [tks_pkg::LIST_DEPTH-1:0]      hit;
  tks_pkg::entry_t                     cell_entry [tks_pkg::LIST_DEPTH];
  tks_pkg::entry_t                     new_entry;
  tks_pkg::cell_ctl_t                  ctl;
  tks_pkg::result_t                    res_nxt;
  tks_pkg::result_t                    res_r;
  logic                                out_valid_r;

  // No command ever stalls, so busy is tied low
  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  assign new_entry.score = in_new_score;
  assign new_entry.ini_a = in_initial_a;
  assign new_entry.ini_b = in_initial_b;
  assign new_entry.ini_c = in_initial_c;

  // Guard the bank number and saturate the read rank
  assign bank_ok = (in_bank < tks_pkg::BANK_W'(tks_pkg::BANKS));
  assign rd_rank = (in_read_rank >= tks_pkg::RANK_W'(tks_pkg::LIST_DEPTH)) ?
                   tks_pkg::RANK_W'(tks_pkg::LAST_RANK) : in_read_rank;

  // Keep an insert only when the offered score beats the last entry
  assign kept      = bank_ok && !cell_ge[tks_pkg::LAST_RANK];
  assign ctl.bank  = bank_ok ? in_bank[tks_pkg::BANK_IDX_W-1:0] : '0;
  assign ctl.wr_en = in_xfer && (in_command == tks_pkg::CMD_INSERT) && kept;

  // Chain of rank cells; cell 0 always sees an upper neighbor that is greater or equal
  for (genvar i = 0; i < tks_pkg::LIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      tks_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .new_entry (new_entry),
        .up_entry  (new_entry),
        .up_ge     (1'b1),
        .cur_entry (cell_entry[i]),
        .cur_ge    (cell_ge[i])
      );
    end else begin : g_body
      tks_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .new_entry (new_entry),
        .up_entry  (cell_entry[i-1]),
        .up_ge     (cell_ge[i-1]),
        .cur_entry (cell_entry[i]),
        .cur_ge    (cell_ge[i])
      );
    end
  end

  // Find the insert spot: first cell whose entry is below the offered score
  always_comb begin
    hit[0]   = !cell_ge[0];
    ins_rank = '0;
    for (int i = 1; i < tks_pkg::LIST_DEPTH; i++) begin
      hit[i] = !cell_ge[i] && cell_ge[i-1];
    end
    for (int i = 0; i < tks_pkg::LIST_DEPTH; i++) begin
      if (hit[i]) begin
        ins_rank = ins_rank | tks_pkg::RANK_W'(i);
      end
    end
  end

  // Build the result item
  always_comb begin
    res_nxt = '0;
    if (bank_ok) begin
      unique case (in_command)
        tks_pkg::CMD_READ: begin
          res_nxt.accepted = 1'b1;
          res_nxt.rank     = rd_rank;
          res_nxt.entry    = cell_entry[rd_rank];
        end
        tks_pkg::CMD_INSERT: begin
          if (kept) begin
            res_nxt.accepted = 1'b1;
            res_nxt.rank     = ins_rank;
            res_nxt.entry    = new_entry;
          end else begin
            res_nxt.accepted = 1'b0;
            res_nxt.rank     = tks_pkg::RANK_W'(tks_pkg::LAST_RANK);
            res_nxt.entry    = cell_entry[tks_pkg::LAST_RANK];
          end
        end
        default: res_nxt = '0;
      endcase
    end
  end

  // Strobe the result for one cycle after each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_xfer;
    end
  end

  // Capture the result payload on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = res_r.accepted;
  assign out_rank            = res_r.rank;
  assign out_entry_score     = res_r.entry.score;
  assign out_entry_initial_a = res_r.entry.ini_a;
  assign out_entry_initial_b = res_r.entry.ini_b;
  assign out_entry_initial_c = res_r.entry.ini_c;

  // The compare results form a prefix, so at most one cell is the insert spot
  `ASSERT_SAME(a_hit_onehot, 1'b1, $onehot0(hit))
  // Each transfer gives exactly one result in the next cycle
  `ASSERT_NEXT(a_result_follows, in_xfer, out_valid)
  `ASSERT_NEXT(a_no_stray_result, !in_xfer, !out_valid)
  // A kept insert is reported as accepted with its own score
  `ASSERT_NEXT(a_insert_lands, ctl.wr_en,
               out_accepted && (out_entry_score == $past(in_new_score)))

endmodule
